FILE: rtl/udpck_pkg.sv
// ----------------------------------------------------------------------------
// udpck_pkg: shared constants for the UDP checksum unit
// Widths and IPv4/UDP header positions for the checksum data path.
// ----------------------------------------------------------------------------
package udpck_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned SumW  = 32;
  localparam int unsigned PosW  = 11;

  localparam logic [PosW-1:0] HdrWords   = PosW'(10);
  localparam logic [PosW-1:0] AddrFirst  = PosW'(6);
  localparam logic [PosW-1:0] UdpLenPos  = PosW'(12);
  localparam logic [PosW-1:0] UdpCsumPos = PosW'(13);
  localparam logic [PosW-1:0] PosMax     = {PosW{1'b1}};

  localparam logic [SumW-1:0]  UdpProto  = SumW'(17);
  localparam logic [WordW-1:0] HighByteMask = 16'hFF00;

  localparam int unsigned MaxSegmentBytesDef = 1500;

endpackage

FILE: rtl/udp_checksum_with_pseudo_header_unit.sv
// ----------------------------------------------------------------------------
// udp_checksum_with_pseudo_header_unit: UDP checksum over an IPv4 packet
// Sums addresses, protocol, UDP length and segment words; emits the folded,
// complemented checksum at the end of each packet.
// ----------------------------------------------------------------------------
// The block takes one 16-bit packet word per cycle, starting at a 20-byte
// IPv4 header, and can sustain one item every clock unless output back-pressure
// fills the queue. A result item is offered after the packet's last item leaves
// the input register: the accumulate stage registers the finished sum, then the
// output register takes it folded and complemented. Only the last
// item of a packet produces a result; the checksum is not remapped from 0 to
// 0xFFFF. Segment words at or past MAX_SEGMENT_BYTES from the UDP header
// start are ignored. Input ready stays high while a result waits, as long as
// no second finished packet is queued behind it.
module udp_checksum_with_pseudo_header_unit #(
  parameter int unsigned MAX_SEGMENT_BYTES = udpck_pkg::MaxSegmentBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [udpck_pkg::WordW-1:0] s_axis_tdata_i,  // [15:0] data_word
  input  logic                        s_axis_tuser_i,  // [0] single_byte
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [udpck_pkg::WordW-1:0] m_axis_tdata_o   // [15:0] checksum
);

  localparam int unsigned WordW = udpck_pkg::WordW;
  localparam int unsigned SumW  = udpck_pkg::SumW;
  localparam int unsigned PosW  = udpck_pkg::PosW;
  localparam logic [PosW-1:0] SegEndPos =
    PosW'(10 + (MAX_SEGMENT_BYTES + 1) / 2);

  logic             in_vld_q, in_single_q, in_last_q;
  logic [WordW-1:0] in_word_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             fin_vld_q;
  logic [SumW-1:0]  fin_sum_q, fin_sum_d;
  logic             out_vld_q;
  logic [WordW-1:0] out_csum_q, out_csum_d;

  logic             out_can, fin_adv, in_consume, in_load;
  logic [WordW-1:0] word_m;
  logic [WordW:0]   contrib;
  logic [SumW-1:0]  sum_add;
  logic [WordW:0]   fold1;
  logic [WordW-1:0] fold2;

  assign out_can    = !out_vld_q || m_axis_tready_i;
  assign fin_adv    = fin_vld_q && out_can;
  assign in_consume = in_vld_q && (!in_last_q || !fin_vld_q || out_can);
  assign in_load    = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !in_vld_q || in_consume;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_csum_q;

  always_comb begin
    word_m  = in_single_q ? (in_word_q & udpck_pkg::HighByteMask) : in_word_q;
    contrib = '0;
    if (pos_q >= udpck_pkg::AddrFirst && pos_q < udpck_pkg::HdrWords) begin
      contrib = {1'b0, word_m};
    end else if (pos_q >= udpck_pkg::HdrWords && pos_q < SegEndPos) begin
      if (pos_q == udpck_pkg::UdpLenPos) begin
        contrib = {word_m, 1'b0};
      end else if (pos_q != udpck_pkg::UdpCsumPos) begin
        contrib = {1'b0, word_m};
      end
    end
    sum_add   = sum_q + SumW'(contrib);
    fin_sum_d = sum_add + udpck_pkg::UdpProto;
    sum_d     = sum_q;
    pos_d     = pos_q;
    if (in_consume) begin
      if (in_last_q) begin
        sum_d = '0;
        pos_d = '0;
      end else begin
        sum_d = sum_add;
        pos_d = (pos_q == udpck_pkg::PosMax) ? pos_q : pos_q + PosW'(1);
      end
    end
  end

  always_comb begin
    fold1      = {1'b0, fin_sum_q[WordW-1:0]} + {1'b0, fin_sum_q[SumW-1:WordW]};
    fold2      = fold1[WordW-1:0] + WordW'(fold1[WordW]);
    out_csum_d = ~fold2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      sum_q     <= '0;
      pos_q     <= '0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= 1'b1;
      end else if (in_consume) begin
        in_vld_q <= 1'b0;
      end
      sum_q <= sum_d;
      pos_q <= pos_d;
      if (in_consume && in_last_q) begin
        fin_vld_q <= 1'b1;
      end else if (fin_adv) begin
        fin_vld_q <= 1'b0;
      end
      if (fin_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_word_q   <= s_axis_tdata_i;
      in_single_q <= s_axis_tuser_i;
      in_last_q   <= s_axis_tlast_i;
    end
    if (in_consume && in_last_q) begin
      fin_sum_q <= fin_sum_d;
    end
    if (fin_adv) begin
      out_csum_q <= out_csum_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_consume && in_last_q |=> pos_q == '0 && sum_q == '0)
    else $error("state not cleared after packet end");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !out_can |=> fin_vld_q && $stable(fin_sum_q))
    else $error("finished sum lost while output stalled");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q && in_last_q && fin_vld_q)
    else $error("input stalled without a queued packet end");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_consume && !in_last_q && pos_q == udpck_pkg::PosMax
    |=> pos_q == udpck_pkg::PosMax)
    else $error("word position wrapped");

endmodule
